FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: design/pp_pkg.sv
// Types and constants of the perspective projection block.
`timescale 1ns / 1ps
package pp_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int DIST_W      = 16;
	localparam int FRAC_W      = 16;
	localparam int CFG_IDX_W   = 2;
	// numerator magnitude: sum of two coordinates, absolute value
	localparam int NMW = COORD_WIDTH + 1;
	// denominator: d*2^16 plus a widened depth
	localparam int DMW = ((COORD_WIDTH + 1 > DIST_W + FRAC_W + 1) ?
		COORD_WIDTH + 1 : DIST_W + FRAC_W + 1) + 1;
	localparam int DSW = DMW + 1;
	// back part latency from queue pop to result: mul, precheck, one stage per bit, output
	localparam int BACK_LAT = COORD_WIDTH + 3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DEN_ZERO = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_DIST,
		REG_OFFSET_X,
		REG_OFFSET_Y,
		REG_OFFSET_Z
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
		logic signed [COORD_WIDTH-1:0] pos_z;
		logic signed [COORD_WIDTH-1:0] aux_value;
	} vertex_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] proj_x;
		logic signed [COORD_WIDTH-1:0] proj_y;
		logic signed [COORD_WIDTH-1:0] proj_z;
		logic signed [COORD_WIDTH-1:0] proj_aux;
		logic [1:0]                    status;
	} result_t;

	typedef struct packed {
		logic [NMW-1:0] mag;
		logic           neg;
	} num_t;

	// classified word handed from front to back
	typedef struct packed {
		num_t [2:0]                    num;
		logic [DMW-1:0]                den_mag;
		logic                          den_neg;
		logic                          den_zero;
		logic [DIST_W-1:0]             vdist;
		logic signed [COORD_WIDTH-1:0] pz;
		logic                          z_ovf;
	} front_word_t;

	// side data the back part carries next to the lanes
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pz;
		logic                          z_ovf;
		logic                          den_zero;
	} side_t;
endpackage

FILE: design/perspective_projection.sv
// Top level of the perspective projection block: registers, queue and lanes.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Projects one vertex (signed Q16.16) per word: offsets are added, then x, y and
// the extra value are scaled by d/(d + z + oz), depth passes through saturated.
// Input channel: a word is taken on a rising edge with start high and busy low.
// Results: result_valid is high for exactly one cycle with the result word; the
// receiver takes it then and cannot hold it off.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is the
// view distance (low 16 bits), 1..3 the x, y, z offsets. cfg_ready is always high.
// Write registers only while no word is in flight.
// Path: an accepted word passes the queue, one register for the
// multiply by d, one for the overflow precheck, one divider stage per quotient bit
// and one output register; the queue is read combinationally, so a word waits there
// only until the next edge.
// Throughput: one word per clock, sustained; the divider is fully pipelined, three
// lanes wide, so busy stays low in use.
// Reset clears the pipeline valids and the queue and loads the register defaults
// (distance 256, offsets zero); words in flight are dropped.
module perspective_projection import pp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  vertex_t               vertex,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data,
	output logic                  result_valid,
	output result_t               result
);
	logic [DIST_W-1:0]             view_distance_q;
	logic signed [COORD_WIDTH-1:0] offset_x_q, offset_y_q, offset_z_q;

	front_word_t fw, bw;
	logic        accept, fifo_full, fifo_empty, pop;

	logic [BACK_LAT-1:0] vld_q;
	side_t               side_q [BACK_LAT];

	logic signed [COORD_WIDTH-1:0] lane_proj [3];
	logic [2:0]                    lane_big;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_distance_q <= DIST_W'(256);
			offset_x_q      <= '0;
			offset_y_q      <= '0;
			offset_z_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_VIEW_DIST: view_distance_q <= cfg_data[DIST_W-1:0];
				REG_OFFSET_X:  offset_x_q      <= cfg_data;
				REG_OFFSET_Y:  offset_y_q      <= cfg_data;
				REG_OFFSET_Z:  offset_z_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: classify the incoming word
	pp_front u_front (
		.vertex        (vertex),
		.view_distance (view_distance_q),
		.offset_x      (offset_x_q),
		.offset_y      (offset_y_q),
		.offset_z      (offset_z_q),
		.word          (fw)
	);

	assign busy   = fifo_full;
	assign accept = start && !busy;
	// back never stalls: drain one word every cycle there is one
	assign pop    = !fifo_empty;

	pp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (fw),
		.pop    (pop),
		.rdata  (bw),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	// back: three identical divider lanes share the denominator
	for (genvar l = 0; l < 3; l++) begin : g_lane
		pp_div_lane u_lane (
			.clk      (clk),
			.num      (bw.num[l]),
			.den_mag  (bw.den_mag),
			.den_neg  (bw.den_neg),
			.den_zero (bw.den_zero),
			.vdist    (bw.vdist),
			.proj     (lane_proj[l]),
			.big      (lane_big[l])
		);
	end

	// valid and depth data walk beside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[BACK_LAT-2:0], pop};
		end
	end

	always_ff @(posedge clk) begin
		side_q[0].pz       <= bw.pz;
		side_q[0].z_ovf    <= bw.z_ovf;
		side_q[0].den_zero <= bw.den_zero;
		for (int i = 1; i < BACK_LAT; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	always_comb begin
		result.proj_x   = lane_proj[0];
		result.proj_y   = lane_proj[1];
		result.proj_aux = lane_proj[2];
		result.proj_z   = side_q[BACK_LAT-1].pz;
		// zero denominator wins over saturation
		if (side_q[BACK_LAT-1].den_zero) begin
			result.status = ST_DEN_ZERO;
		end else if ((lane_big != '0) || side_q[BACK_LAT-1].z_ovf) begin
			result.status = ST_OVERFLOW;
		end else begin
			result.status = ST_OK;
		end
	end

	assign result_valid = vld_q[BACK_LAT-1];

	`PP_ASSERT_IMP(a_latency, clk, arst_n, start && !busy, ##(BACK_LAT+1) result_valid, "accepted word gave no result at the fixed latency")
	`PP_ASSERT_NEVER(a_no_stall, clk, arst_n, busy, "queue filled although the back part drains every cycle")
	`PP_ASSERT_IMP(a_dz_sat, clk, arst_n, result_valid && result.status == ST_OK, lane_big == '0, "status ok with a saturated lane")
endmodule

FILE: design/pp_front.sv
// Front part: offset add, denominator forming and classification.
`timescale 1ns / 1ps
module pp_front import pp_pkg::*; (
	input  vertex_t                       vertex,
	input  logic [DIST_W-1:0]             view_distance,
	input  logic signed [COORD_WIDTH-1:0] offset_x,
	input  logic signed [COORD_WIDTH-1:0] offset_y,
	input  logic signed [COORD_WIDTH-1:0] offset_z,
	output front_word_t                   word
);
	logic signed [COORD_WIDTH:0] xs, ys, zs, as;
	logic signed [DSW-1:0]       den;
	logic [DSW-1:0]              dfix;

	function automatic num_t to_num(input logic signed [COORD_WIDTH:0] v);
		num_t n;
		n.neg = v[COORD_WIDTH];
		n.mag = n.neg ? NMW'(-v) : NMW'(v);
		return n;
	endfunction

	always_comb begin
		xs   = {vertex.pos_x[COORD_WIDTH-1], vertex.pos_x}
			+ {offset_x[COORD_WIDTH-1], offset_x};
		ys   = {vertex.pos_y[COORD_WIDTH-1], vertex.pos_y}
			+ {offset_y[COORD_WIDTH-1], offset_y};
		zs   = {vertex.pos_z[COORD_WIDTH-1], vertex.pos_z}
			+ {offset_z[COORD_WIDTH-1], offset_z};
		as   = {vertex.aux_value[COORD_WIDTH-1], vertex.aux_value};
		dfix = DSW'({view_distance, {FRAC_W{1'b0}}});
		den  = $signed(dfix) + DSW'(zs);

		word.num[0]   = to_num(xs);
		word.num[1]   = to_num(ys);
		word.num[2]   = to_num(as);
		word.den_neg  = den[DSW-1];
		word.den_mag  = den[DSW-1] ? DMW'(-den) : DMW'(den);
		word.den_zero = (den == '0);
		word.vdist    = view_distance;
		// depth saturates when the extra top bit disagrees with the sign
		word.z_ovf    = zs[COORD_WIDTH] != zs[COORD_WIDTH-1];
		if (!word.z_ovf) begin
			word.pz = zs[COORD_WIDTH-1:0];
		end else if (zs[COORD_WIDTH]) begin
			word.pz = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end else begin
			word.pz = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end
	end
endmodule

FILE: design/pp_fifo.sv
// Two-entry queue between front and back part.
`timescale 1ns / 1ps
module pp_fifo import pp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  front_word_t wdata,
	input  logic        pop,
	output front_word_t rdata,
	output logic        full,
	output logic        empty
);
	front_word_t mem_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
endmodule

FILE: design/pp_div_lane.sv
// One projection lane: multiply by d, then a restoring divider, one bit per stage.
`timescale 1ns / 1ps
module pp_div_lane import pp_pkg::*; (
	input  logic                          clk,
	input  num_t                          num,
	input  logic [DMW-1:0]                den_mag,
	input  logic                          den_neg,
	input  logic                          den_zero,
	input  logic [DIST_W-1:0]             vdist,
	output logic signed [COORD_WIDTH-1:0] proj,
	output logic                          big
);
	localparam int PRW = NMW + DIST_W;
	localparam int PW  = PRW + FRAC_W;
	localparam int HW  = PW - COORD_WIDTH;
	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// flags that ride with the value: quotient negative, numerator nonzero/negative,
	// zero denominator, early overflow
	typedef struct packed {
		logic neg;
		logic nz;
		logic nneg;
		logic dz;
		logic big;
	} lane_flags_t;

	logic [PRW-1:0]         prod_s1;
	logic [DMW-1:0]         c_s1;
	lane_flags_t            fl_s1;
	logic [PW-1:0]          p_full;
	logic [HW-1:0]          p_hi;

	logic [DMW-1:0]         rem_s   [COORD_WIDTH+1];
	logic [COORD_WIDTH-1:0] quo_s   [COORD_WIDTH+1];
	logic [COORD_WIDTH-1:0] lo_s    [COORD_WIDTH+1];
	logic [DMW-1:0]         c_s     [COORD_WIDTH+1];
	lane_flags_t            fl_s    [COORD_WIDTH+1];

	logic [COORD_WIDTH-1:0] q_fin;
	lane_flags_t            fl_fin;
	logic                   ovf_fin;
	logic signed [COORD_WIDTH-1:0] proj_d;

	always_ff @(posedge clk) begin
		prod_s1     <= PRW'(num.mag) * PRW'(vdist);
		c_s1        <= den_mag;
		fl_s1.neg   <= num.neg ^ den_neg;
		fl_s1.nz    <= (num.mag != '0);
		fl_s1.nneg  <= num.neg;
		fl_s1.dz    <= den_zero;
		fl_s1.big   <= 1'b0;
	end

	assign p_full = {prod_s1, {FRAC_W{1'b0}}};
	assign p_hi   = p_full[PW-1:COORD_WIDTH];

	// quotient would need more than COORD_WIDTH bits when hi >= c
	always_ff @(posedge clk) begin
		rem_s[0] <= DMW'(p_hi);
		quo_s[0] <= '0;
		lo_s[0]  <= p_full[COORD_WIDTH-1:0];
		c_s[0]   <= c_s1;
		fl_s[0]  <= '{neg: fl_s1.neg, nz: fl_s1.nz, nneg: fl_s1.nneg, dz: fl_s1.dz,
			big: (DMW'(p_hi) >= c_s1)};
	end

	for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_step
		logic [DMW:0] t;
		logic         ge;
		assign t  = {rem_s[k], lo_s[k][COORD_WIDTH-1]};
		assign ge = (t >= {1'b0, c_s[k]});
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? DMW'(t - {1'b0, c_s[k]}) : t[DMW-1:0];
			quo_s[k+1] <= {quo_s[k][COORD_WIDTH-2:0], ge};
			lo_s[k+1]  <= {lo_s[k][COORD_WIDTH-2:0], 1'b0};
			c_s[k+1]   <= c_s[k];
			fl_s[k+1]  <= fl_s[k];
		end
	end

	always_comb begin
		q_fin  = quo_s[COORD_WIDTH];
		fl_fin = fl_s[COORD_WIDTH];
		// negative side may reach one past the positive bound
		ovf_fin = fl_fin.big || (fl_fin.neg ?
			(q_fin[COORD_WIDTH-1] && (q_fin[COORD_WIDTH-2:0] != '0)) :
			q_fin[COORD_WIDTH-1]);
		if (fl_fin.dz) begin
			proj_d = !fl_fin.nz ? '0 : (fl_fin.nneg ? CMIN : CMAX);
		end else if (ovf_fin) begin
			proj_d = fl_fin.neg ? CMIN : CMAX;
		end else begin
			proj_d = fl_fin.neg ? -$signed(q_fin) : $signed(q_fin);
		end
	end

	always_ff @(posedge clk) begin
		proj <= proj_d;
		big  <= !fl_fin.dz && ovf_fin;
	end
endmodule

FILE: test/pp_checker.sv
// Checker for the perspective projection block: predicts every vertex word and compares results.
`timescale 1ns / 1ps
module pp_checker import pp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  vertex_t                vertex,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data,
	input  logic                   result_valid,
	input  result_t                result,
	output int                     errors,
	output int                     pending
);
	localparam longint CMAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;

	logic [DIST_W-1:0] vdist;
	longint            off_x, off_y, off_z;
	result_t           projected_q[$];

	// scale one coordinate by dfix/den, truncating toward zero
	function automatic logic [COORD_WIDTH-1:0] scale(longint num, longint dfix, longint den,
			inout bit den_hit, inout bit ovf);
		bit           neg;
		longint       nmag, dmag, cap;
		logic [127:0] quo;
		if (den == 0) begin
			den_hit = 1;
			return COORD_WIDTH'((num > 0) ? CMAX : ((num < 0) ? CMIN : 64'sd0));
		end
		neg  = (num < 0) != (den < 0);
		nmag = (num < 0) ? -num : num;
		dmag = (den < 0) ? -den : den;
		cap  = neg ? CMAX + 1 : CMAX;
		quo  = (128'(nmag) * 128'(dfix)) / 128'(dmag);
		if (quo > 128'(cap)) begin
			ovf = 1;
			return COORD_WIDTH'(neg ? CMIN : CMAX);
		end
		return COORD_WIDTH'(neg ? -longint'(quo) : longint'(quo));
	endfunction

	function automatic result_t project_vertex(vertex_t v);
		result_t r;
		longint  dfix, xs, ys, zs, den;
		bit      den_hit, ovf;
		den_hit = 0;
		ovf     = 0;
		dfix    = longint'(vdist) << FRAC_W;
		xs      = longint'(v.pos_x) + off_x;
		ys      = longint'(v.pos_y) + off_y;
		zs      = longint'(v.pos_z) + off_z;
		den     = dfix + zs;
		r.proj_x   = scale(xs, dfix, den, den_hit, ovf);
		r.proj_y   = scale(ys, dfix, den, den_hit, ovf);
		r.proj_aux = scale(longint'(v.aux_value), dfix, den, den_hit, ovf);
		if (zs > CMAX) begin
			r.proj_z = COORD_WIDTH'(CMAX);
			ovf = 1;
		end else if (zs < CMIN) begin
			r.proj_z = COORD_WIDTH'(CMIN);
			ovf = 1;
		end else begin
			r.proj_z = COORD_WIDTH'(zs);
		end
		r.status = den_hit ? ST_DEN_ZERO : (ovf ? ST_OVERFLOW : ST_OK);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			vdist = 16'd256;
			off_x = 0;
			off_y = 0;
			off_z = 0;
			projected_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			// the word taken at this edge still sees the old registers
			if (start && !busy)
				projected_q = {projected_q, project_vertex(vertex)};
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_VIEW_DIST: vdist = cfg_data[DIST_W-1:0];
					REG_OFFSET_X:  off_x = longint'(signed'(cfg_data));
					REG_OFFSET_Y:  off_y = longint'(signed'(cfg_data));
					REG_OFFSET_Z:  off_z = longint'(signed'(cfg_data));
					default: ;
				endcase
			end
			if (result_valid) begin
				if (projected_q.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					exp_r = projected_q.pop_front();
					if (result.proj_x !== exp_r.proj_x) begin
						$error("proj_x expected %h actual %h", exp_r.proj_x, result.proj_x);
						errors++;
					end
					if (result.proj_y !== exp_r.proj_y) begin
						$error("proj_y expected %h actual %h", exp_r.proj_y, result.proj_y);
						errors++;
					end
					if (result.proj_z !== exp_r.proj_z) begin
						$error("proj_z expected %h actual %h", exp_r.proj_z, result.proj_z);
						errors++;
					end
					if (result.proj_aux !== exp_r.proj_aux) begin
						$error("proj_aux expected %h actual %h", exp_r.proj_aux,
							result.proj_aux);
						errors++;
					end
					if (result.status !== exp_r.status) begin
						$error("status expected %0d actual %0d", exp_r.status, result.status);
						errors++;
					end
				end
			end
			pending = projected_q.size();
		end
	end
endmodule

FILE: test/tb.sv
// Testbench top for the perspective projection block: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
	import pp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int PHASES = 6;

	logic                   clk = 0;
	logic                   arst_n = 0;
	logic                   start = 0;
	logic                   busy;
	vertex_t                vertex = '0;
	logic                   cfg_valid = 0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [COORD_WIDTH-1:0] cfg_data = '0;
	logic                   result_valid;
	result_t                result;
	int                     errors, pending;
	int                     quiet_cycles = 0;

	// local copy of the two registers that decide a zero denominator
	longint cur_dist = 256;
	longint cur_oz = 0;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	perspective_projection u_dut (
		.clk, .arst_n, .start, .busy, .vertex, .cfg_valid, .cfg_ready,
		.cfg_index, .cfg_data, .result_valid, .result
	);

	pp_checker u_chk (
		.clk, .arst_n, .start, .busy, .vertex, .cfg_valid, .cfg_ready,
		.cfg_index, .cfg_data, .result_valid, .result, .errors, .pending
	);

	// watchdog: any accepted word resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Called right after a rising edge. Keeps start high when no gap is wanted,
	// so a back-to-back word never sees start lowered and raised in one step.
	task automatic send_vertex(vertex_t v, int gap);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1;
		vertex <= v;
		forever begin
			@(negedge clk);
			if (!busy) begin
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
	endtask

	// wait until every result is in; every word makes exactly one result
	task automatic drain;
		start <= 0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(cfg_reg_t idx, logic [COORD_WIDTH-1:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= data;
		forever begin
			@(negedge clk);
			if (cfg_ready) begin
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
		if (idx == REG_VIEW_DIST)
			cur_dist = longint'(data[DIST_W-1:0]);
		if (idx == REG_OFFSET_Z)
			cur_oz = longint'(signed'(data));
	endtask

	task automatic set_regs(logic [15:0] d, logic [31:0] ox, logic [31:0] oy,
			logic [31:0] oz);
		write_reg(REG_VIEW_DIST, {16'h0, d});
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_OFFSET_Z, oz);
		cfg_valid <= 0;
	endtask

	// mix of full-range, extreme, small and typical Q16.16 values
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(4))
			0: return $urandom;
			1: case ($urandom_range(4))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0;
				3: return 32'h1;
				default: return 32'hFFFF_FFFF;
			endcase
			2: return $urandom_range(0, 32'h3F_FFFF) ^ {32{$urandom_range(1) == 1}};
			default: return 32'($urandom_range(0, 2000 << 16)) - (1000 << 16);
		endcase
	endfunction

	// depth that drives the denominator to zero, or a random one when unreachable
	function automatic logic [31:0] zero_den_z();
		longint z;
		z = -(cur_dist << FRAC_W) - cur_oz;
		if (z > 64'sh7FFF_FFFF || z < -64'sh8000_0000)
			return rand_coord();
		return z[31:0];
	endfunction

	function automatic int pick_gap(int n);
		// long run with no gaps in the middle of the random part
		if (n >= 300 && n < 450)
			return 0;
		return ($urandom_range(99) < 21) ? $urandom_range(1, 6) : 0;
	endfunction

	initial begin
		vertex_t v;
		logic [31:0] ox, oy, oz;
		int n;
		n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part at reset settings: d = 256, offsets zero
		send_vertex('{32'h0, 32'h0, 32'h0, 32'h0}, 0);
		send_vertex('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0);
		send_vertex('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0);
		send_vertex('{32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000}, 1);
		// zero denominator: positive, negative and zero numerators
		send_vertex('{32'h0001_0000, 32'hFFFF_0000, 32'hFF00_0000, 32'h0}, 0);
		send_vertex('{32'h0, 32'h7FFF_FFFF, 32'hFF00_0000, 32'h8000_0000}, 0);
		// tiny positive denominator forces overflow
		send_vertex('{32'h7FFF_FFFF, 32'h1, 32'hFF00_0001, 32'h0}, 0);
		send_vertex('{32'h8000_0000, 32'h0, 32'hFF00_0001, 32'h1}, 2);
		drain();

		// view distance zero: scaled results vanish unless the denominator is zero
		set_regs(16'h0, 32'h0, 32'h0, 32'h0);
		send_vertex('{32'h1234_5678, 32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF}, 0);
		send_vertex('{32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000}, 0);
		drain();

		// extreme offsets: depth and x/y sums leave the range
		set_regs(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_vertex('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0}, 0);
		send_vertex('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000}, 0);
		send_vertex('{32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000}, 0);
		drain();
		set_regs(16'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_vertex('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0);
		send_vertex('{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0001_0000}, 0);
		send_vertex('{32'h0, 32'h0, zero_den_z(), 32'hFFFF_FFFF}, 0);
		drain();

		// random part: one setting per phase, extremes in the first four
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin ox = 0; oy = 0; oz = 0; end
				2: begin ox = 32'h7FFF_FFFF; oy = 32'h7FFF_FFFF; oz = 32'h7FFF_FFFF; end
				3: begin ox = 32'h8000_0000; oy = 32'h8000_0000; oz = 32'h8000_0000; end
				default: begin ox = rand_coord(); oy = rand_coord(); oz = rand_coord(); end
			endcase
			set_regs((p == 0) ? 16'd1 : (p == 1) ? 16'hFFFF : 16'($urandom_range(1, 65535)),
				ox, oy, oz);
			repeat (ITEMS_PER_PHASE) begin
				v.pos_x     = rand_coord();
				v.pos_y     = rand_coord();
				v.pos_z     = ($urandom_range(99) < 6) ? zero_den_z() : rand_coord();
				v.aux_value = rand_coord();
				send_vertex(v, pick_gap(n));
				n++;
			end
			drain();
		end

		repeat (BACK_LAT + 4) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
